// ----- rtl/core/ehcd_pkg.sv -----
package ehcd_pkg;

  localparam int NUM_CALLS = 6;
  localparam int BTN_IDX_W = $clog2(NUM_CALLS);

  typedef logic [BTN_IDX_W-1:0] btn_idx_t;
  typedef logic [5:0]           score_t;
  typedef logic [NUM_CALLS-1:0] call_mask_t;

  // Owner codes of a hall button.
  typedef enum logic [1:0] {
    OWN_NONE = 2'd0,
    OWN_A    = 2'd1,
    OWN_B    = 2'd2
  } owner_e;

  // Request types.
  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  // Car motion codes; every other code means idle.
  localparam logic [2:0] MOT_UP    = 3'd1;
  localparam logic [2:0] MOT_DOWN  = 3'd2;
  localparam logic [2:0] MOT_EMERG = 3'd4;

  localparam score_t PEN_PASSED = 6'd10;
  localparam score_t PEN_OTHER  = 6'd20;

  typedef struct packed {
    logic       req_type;
    logic [3:0] press_floor;
    logic       press_dir;
    logic       link_fault;
    logic [3:0] a_floor;
    logic [2:0] a_state;
    logic       a_door_open;
    logic [3:0] b_floor;
    logic [2:0] b_state;
    logic       b_door_open;
  } in_t;

  typedef struct packed {
    logic       forward_valid;
    logic [3:0] forward_floor;
    call_mask_t active_mask;
    call_mask_t owner_a_mask;
    call_mask_t owner_b_mask;
  } out_t;

  // Floor served by each button, in scan order.
  function automatic logic [3:0] btn_floor(btn_idx_t idx);
    logic [3:0] f;
    case (idx)
      3'd0:    f = 4'd1;
      3'd1:    f = 4'd2;
      3'd2:    f = 4'd2;
      3'd3:    f = 4'd3;
      3'd4:    f = 4'd3;
      3'd5:    f = 4'd4;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

  // Direction of each button: 1 for down.
  function automatic logic btn_down(btn_idx_t idx);
    logic d;
    case (idx)
      3'd1, 3'd3, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/ehcd_score_unit.sv -----
module ehcd_score_unit (
  input  logic [3:0]      car_floor_i,
  input  logic [2:0]      motion_i,
  input  logic [3:0]      btn_floor_i,
  input  logic            btn_down_i,
  output ehcd_pkg::score_t score_o
);
  import ehcd_pkg::*;

  logic [3:0] gap;
  logic       idle;

  // Distance plus a penalty for a car moving away or past the call.
  always_comb begin
    gap  = (car_floor_i > btn_floor_i) ? (car_floor_i - btn_floor_i)
                                       : (btn_floor_i - car_floor_i);
    idle = !(motion_i inside {MOT_UP, MOT_DOWN, MOT_EMERG});
    if (idle) begin
      score_o = {2'b00, gap};
    end else if (motion_i == MOT_UP && !btn_down_i) begin
      score_o = (car_floor_i < btn_floor_i) ? {2'b00, gap} : PEN_PASSED + {2'b00, gap};
    end else if (motion_i == MOT_DOWN && btn_down_i) begin
      score_o = (car_floor_i > btn_floor_i) ? {2'b00, gap} : PEN_PASSED + {2'b00, gap};
    end else begin
      score_o = PEN_OTHER + {2'b00, gap};
    end
  end

endmodule

// ----- rtl/core/elevator_hall_call_dispatch.sv -----
// Two-car hall-call dispatcher. Six hall buttons are held in the order
// 1-up, 2-down, 2-up, 3-down, 3-up, 4-down, each with an active flag and an
// owner (none, car A, car B). A register beat (req_type 0) marks its button
// active in ST_REG when the button has no owner, and its result beat is
// offered in ST_DONE after that. A dispatch tick (req_type 1) walks the six
// buttons, each through ST_SCORE_A and then ST_SCORE_B, because one shared
// scoring unit rates car A in the first state and car B in the second; after
// the last button the tick offers its result beat in ST_DONE. The block holds
// one item at a time: in_stall_o stays high from acceptance until the result
// beat has been taken, and the next beat is accepted only once the block is
// back in ST_IDLE. Unowned active buttons go to the car with the lower score,
// ties and every call under link_fault go to A, and a button is cleared on
// the tick when its owner stands at its floor with the door open, including a
// button assigned on that same tick. The result beat carries the button masks
// after the item and, for ticks, the floor of the last button handed to
// car B. After reset all buttons are inactive and unowned.
module elevator_hall_call_dispatch (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ehcd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ehcd_pkg::out_t out_data_o
);
  import ehcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_SCORE_A,
    ST_SCORE_B,
    ST_DONE
  } state_e;

  localparam btn_idx_t LAST_IDX = btn_idx_t'(NUM_CALLS - 1);

  state_e     state_q;
  in_t        item_q;
  btn_idx_t   idx_q;
  score_t     score_a_q;
  logic       fwd_valid_q;
  logic [3:0] fwd_floor_q;
  logic       active_q [NUM_CALLS];
  owner_e     owner_q  [NUM_CALLS];

  logic       in_beat;
  logic       out_beat;
  logic [3:0] cur_floor;
  logic       cur_down;
  logic [3:0] unit_car_floor;
  logic [2:0] unit_motion;
  score_t     unit_score;
  call_mask_t reg_hit;
  owner_e     own_new;
  logic       clear_cur;
  call_mask_t act_mask;
  call_mask_t own_a_mask;
  call_mask_t own_b_mask;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  assign cur_floor = btn_floor(idx_q);
  assign cur_down  = btn_down(idx_q);

  // The scoring unit sees car A in ST_SCORE_A of a button, car B in ST_SCORE_B.
  always_comb begin
    if (state_q == ST_SCORE_B) begin
      unit_car_floor = item_q.b_floor;
      unit_motion    = item_q.b_state;
    end else begin
      unit_car_floor = item_q.a_floor;
      unit_motion    = item_q.a_state;
    end
  end

  ehcd_score_unit u_score (
    .car_floor_i (unit_car_floor),
    .motion_i    (unit_motion),
    .btn_floor_i (cur_floor),
    .btn_down_i  (cur_down),
    .score_o     (unit_score)
  );

  // Register beat: the first button that matches floor and direction.
  always_comb begin
    logic found;
    found   = 1'b0;
    reg_hit = '0;
    for (int i = 0; i < NUM_CALLS; i++) begin
      if (!found && btn_floor(btn_idx_t'(i)) == item_q.press_floor &&
          btn_down(btn_idx_t'(i)) == item_q.press_dir) begin
        found      = 1'b1;
        reg_hit[i] = 1'b1;
      end
    end
  end

  // Assignment of the current button and the clearing check that follows it.
  always_comb begin
    own_new = owner_q[idx_q];
    if (active_q[idx_q] && owner_q[idx_q] == OWN_NONE) begin
      if (item_q.link_fault || score_a_q <= unit_score) begin
        own_new = OWN_A;
      end else begin
        own_new = OWN_B;
      end
    end
    clear_cur = (own_new == OWN_A && item_q.a_floor == cur_floor && item_q.a_door_open) ||
                (own_new == OWN_B && item_q.b_floor == cur_floor && item_q.b_door_open);
  end

  always_comb begin
    for (int i = 0; i < NUM_CALLS; i++) begin
      act_mask[i]   = active_q[i];
      own_a_mask[i] = (owner_q[i] == OWN_A);
      own_b_mask[i] = (owner_q[i] == OWN_B);
    end
  end

  assign out_data_o.forward_valid = fwd_valid_q;
  assign out_data_o.forward_floor = fwd_floor_q;
  assign out_data_o.active_mask   = act_mask;
  assign out_data_o.owner_a_mask  = own_a_mask;
  assign out_data_o.owner_b_mask  = own_b_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      fwd_valid_q <= 1'b0;
      fwd_floor_q <= '0;
      for (int i = 0; i < NUM_CALLS; i++) begin
        active_q[i] <= 1'b0;
        owner_q[i]  <= OWN_NONE;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            item_q      <= in_data_i;
            idx_q       <= '0;
            fwd_valid_q <= 1'b0;
            fwd_floor_q <= '0;
            state_q     <= (in_data_i.req_type == REQ_TICK) ? ST_SCORE_A : ST_REG;
          end
        end
        ST_REG: begin
          for (int i = 0; i < NUM_CALLS; i++) begin
            if (reg_hit[i] && owner_q[i] == OWN_NONE) begin
              active_q[i] <= 1'b1;
            end
          end
          state_q <= ST_DONE;
        end
        ST_SCORE_A: begin
          score_a_q <= unit_score;
          state_q   <= ST_SCORE_B;
        end
        ST_SCORE_B: begin
          if (own_new == OWN_B && owner_q[idx_q] == OWN_NONE) begin
            fwd_valid_q <= 1'b1;
            fwd_floor_q <= cur_floor;
          end
          if (clear_cur) begin
            active_q[idx_q] <= 1'b0;
            owner_q[idx_q]  <= OWN_NONE;
          end else begin
            owner_q[idx_q]  <= own_new;
          end
          if (idx_q == LAST_IDX) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_q + btn_idx_t'(1);
            state_q <= ST_SCORE_A;
          end
        end
        ST_DONE: begin
          if (out_beat) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A button never has two owners.
  a_owner_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (own_a_mask & own_b_mask) == '0)
    else $error("button owned by both cars");

  // An owned button is always active.
  a_owned_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((own_a_mask | own_b_mask) & ~act_mask) == '0)
    else $error("owned button is not active");

  // Without a forward the forwarded floor reads zero.
  a_fwd_floor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.forward_valid |-> out_data_o.forward_floor == 4'd0)
    else $error("forward floor set without forward");

  // A register beat never forwards a call.
  a_reg_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_q.req_type == REQ_REGISTER |-> !out_data_o.forward_valid)
    else $error("register beat forwarded a call");

  // An accepted beat holds the input side until its result is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o && !out_valid_o)
    else $error("input side not held after accept");

endmodule

// ----- verif/elevator_hall_call_dispatch_checker.sv -----
module elevator_hall_call_dispatch_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  ehcd_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  ehcd_pkg::out_t out_data_i,
  output int             mismatch_count_o,
  output int             beats_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ehcd_pkg::*;

  // Hall buttons in scan order: 1-up, 2-down, 2-up, 3-down, 3-up, 4-down.
  localparam logic [NUM_CALLS*4-1:0] HALL_FLOORS = {4'd4, 4'd3, 4'd3, 4'd2, 4'd2, 4'd1};
  localparam call_mask_t             HALL_DOWN   = 6'b101010;

  logic   hall_active [NUM_CALLS];
  owner_e hall_owner  [NUM_CALLS];
  out_t   hall_results [$];
  out_t   want;

  // Distance plus a direction penalty; the lower cost wins the call.
  function automatic int car_cost(logic [3:0] car_floor, logic [2:0] motion,
                                  logic [3:0] floor, logic down);
    int span;
    span = (car_floor > floor) ? car_floor - floor : floor - car_floor;
    if (motion == MOT_UP && !down)
      return (car_floor < floor) ? span : PEN_PASSED + span;
    if (motion == MOT_DOWN && down)
      return (car_floor > floor) ? span : PEN_PASSED + span;
    if (motion inside {MOT_UP, MOT_DOWN, MOT_EMERG})
      return PEN_OTHER + span;
    return span;
  endfunction

  // Applies one request beat to the button table and returns the result beat.
  function automatic out_t dispatch_outcome(in_t beat);
    out_t       res;
    owner_e     winner;
    logic [3:0] fl;
    logic       matched;
    res     = '0;
    matched = 1'b0;
    if (beat.req_type == REQ_REGISTER) begin
      for (int i = 0; i < NUM_CALLS; i++) begin
        if (!matched && HALL_FLOORS[4*i +: 4] == beat.press_floor &&
            HALL_DOWN[i] == beat.press_dir) begin
          matched = 1'b1;
          if (hall_owner[i] == OWN_NONE) hall_active[i] = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < NUM_CALLS; i++) begin
        fl = HALL_FLOORS[4*i +: 4];
        if (hall_active[i] && hall_owner[i] == OWN_NONE) begin
          winner = OWN_A;
          if (!beat.link_fault &&
              car_cost(beat.a_floor, beat.a_state, fl, HALL_DOWN[i]) >
              car_cost(beat.b_floor, beat.b_state, fl, HALL_DOWN[i]))
            winner = OWN_B;
          hall_owner[i] = winner;
          if (winner == OWN_B) begin
            res.forward_valid = 1'b1;
            res.forward_floor = fl;
          end
        end
        // A call handed out on this very tick may be served at once.
        if ((hall_owner[i] == OWN_A && beat.a_floor == fl && beat.a_door_open) ||
            (hall_owner[i] == OWN_B && beat.b_floor == fl && beat.b_door_open)) begin
          hall_active[i] = 1'b0;
          hall_owner[i]  = OWN_NONE;
        end
      end
    end
    for (int i = 0; i < NUM_CALLS; i++) begin
      res.active_mask[i]  = hall_active[i];
      res.owner_a_mask[i] = (hall_owner[i] == OWN_A);
      res.owner_b_mask[i] = (hall_owner[i] == OWN_B);
    end
    return res;
  endfunction

  function automatic int field_differs(string name, int expected_val, int actual_val);
    if (expected_val == actual_val) return 0;
    $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CALLS; i++) begin
        hall_active[i] = 1'b0;
        hall_owner[i]  = OWN_NONE;
      end
      hall_results.delete();
      mismatch_count_o = 0;
      beats_pending_o  = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        hall_results.push_back(dispatch_outcome(in_data_i));
        beats_pending_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (hall_results.size() == 0) begin
          $error("result beat %h arrived with nothing outstanding", out_data_i);
          mismatch_count_o++;
        end else begin
          want = hall_results.pop_front();
          beats_pending_o--;
          mismatch_count_o += field_differs("forward_valid", want.forward_valid,
                                            out_data_i.forward_valid);
          mismatch_count_o += field_differs("forward_floor", want.forward_floor,
                                            out_data_i.forward_floor);
          mismatch_count_o += field_differs("active_mask", want.active_mask,
                                            out_data_i.active_mask);
          mismatch_count_o += field_differs("owner_a_mask", want.owner_a_mask,
                                            out_data_i.owner_a_mask);
          mismatch_count_o += field_differs("owner_b_mask", want.owner_b_mask,
                                            out_data_i.owner_b_mask);
        end
      end
    end
  end

endmodule

// ----- verif/elevator_hall_call_dispatch_tb.sv -----
module elevator_hall_call_dispatch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ehcd_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  int   mismatches;
  int   outstanding;
  int   beats_sent;
  logic calm;

  // A window of beats in which neither side inserts any idle cycles, so the
  // block runs back to back.
  assign calm = (beats_sent >= 500) && (beats_sent < 650);

  elevator_hall_call_dispatch DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  elevator_hall_call_dispatch_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatches),
    .beats_pending_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // A beat with every field drawn at random. Most register beats name one of
  // the six real buttons; the rest use a random floor and direction, mostly with no button.
  // Car floors mostly stay near the buttons so that doors open where calls
  // wait and clearing actually happens.
  function automatic in_t random_beat();
    in_t b;
    int  btn;
    b.link_fault  = ($urandom_range(99) < 12);
    b.a_floor     = ($urandom_range(99) < 75) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
    b.a_state     = 3'($urandom_range(7));
    b.a_door_open = 1'($urandom_range(1));
    b.b_floor     = ($urandom_range(99) < 75) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
    b.b_state     = 3'($urandom_range(7));
    b.b_door_open = 1'($urandom_range(1));
    b.press_floor = 4'($urandom_range(15));
    b.press_dir   = 1'($urandom_range(1));
    if ($urandom_range(99) < 55) begin
      b.req_type = REQ_REGISTER;
      if ($urandom_range(99) < 85) begin
        // Button index to floor: 0->1, 1->2, 2->2, 3->3, 4->3, 5->4; odd is down.
        btn           = $urandom_range(NUM_CALLS - 1);
        b.press_floor = 4'(btn / 2 + btn % 2 + 1);
        b.press_dir   = 1'(btn % 2);
      end
    end else begin
      b.req_type = REQ_TICK;
    end
    return b;
  endfunction

  // Hall button press; the car fields are random since a press ignores them.
  function automatic in_t press_beat(int floor, logic dir);
    in_t b;
    b             = random_beat();
    b.req_type    = REQ_REGISTER;
    b.press_floor = 4'(floor);
    b.press_dir   = dir;
    return b;
  endfunction

  // Dispatch tick with both cars fully specified.
  function automatic in_t tick_beat(logic fault, int af, logic [2:0] as, logic ad,
                                    int bf, logic [2:0] bs, logic bd);
    in_t b;
    b             = random_beat();
    b.req_type    = REQ_TICK;
    b.link_fault  = fault;
    b.a_floor     = 4'(af);
    b.a_state     = as;
    b.a_door_open = ad;
    b.b_floor     = 4'(bf);
    b.b_state     = bs;
    b.b_door_open = bd;
    return b;
  endfunction

  // Offers one beat and returns at the falling edge after it was taken. The
  // caller is always at a falling edge, so valid is written once per step.
  task automatic offer_beat(input in_t beat);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // The sender goes quiet until every result beat has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Result side. Stalls at random, except in the calm window, and once holds
  // off for a long stretch so that the block backs up into its input.
  initial begin
    int   hold_left;
    logic hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && beats_sent >= 300) begin
        hold_left = 250;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 27);
      end
    end
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    beats_sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Press every real button once.
    offer_beat(press_beat(1, 1'b0));
    offer_beat(press_beat(2, 1'b1));
    offer_beat(press_beat(2, 1'b0));
    offer_beat(press_beat(3, 1'b1));
    offer_beat(press_beat(3, 1'b0));
    offer_beat(press_beat(4, 1'b1));
    // Floor and direction pairs with no button behind them change nothing.
    offer_beat(press_beat(0, 1'b0));
    offer_beat(press_beat(15, 1'b1));
    offer_beat(press_beat(1, 1'b1));
    offer_beat(press_beat(4, 1'b0));
    // A climbs from the ground while B descends from the top: up calls go to
    // A, down calls to B, and the last one handed to B is forwarded.
    offer_beat(tick_beat(1'b0, 0, MOT_UP, 1'b0, 15, MOT_DOWN, 1'b0));
    // Pressing a button that already has an owner is ignored.
    offer_beat(press_beat(2, 1'b1));
    // Under a link fault, with both doors open at owned floors.
    offer_beat(tick_beat(1'b1, 1, 3'd3, 1'b1, 4, 3'd0, 1'b1));
    offer_beat(tick_beat(1'b0, 2, 3'd0, 1'b1, 3, 3'd0, 1'b1));
    // Every car field at its largest value.
    offer_beat(tick_beat(1'b0, 15, 3'd7, 1'b1, 15, 3'd7, 1'b1));
    // A button handed to A under a fault is served by A on the same tick.
    offer_beat(press_beat(1, 1'b0));
    offer_beat(press_beat(3, 1'b0));
    offer_beat(tick_beat(1'b1, 1, 3'd3, 1'b1, 0, 3'd0, 1'b0));
    // A in emergency loses against an idle B.
    offer_beat(press_beat(3, 1'b1));
    offer_beat(press_beat(2, 1'b0));
    offer_beat(tick_beat(1'b0, 3, MOT_EMERG, 1'b0, 5, 3'd5, 1'b0));
    // Both cars moving past calls: passed penalty against wrong direction.
    offer_beat(press_beat(4, 1'b1));
    offer_beat(press_beat(1, 1'b0));
    offer_beat(tick_beat(1'b0, 5, MOT_UP, 1'b0, 0, MOT_DOWN, 1'b0));
    // Every car field at zero.
    offer_beat(tick_beat(1'b0, 0, 3'd0, 1'b0, 0, 3'd0, 1'b0));
    drain_results();

    for (int n = 0; n < 1000; n++) begin
      if (n == 700) drain_results();
      offer_beat(random_beat());
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
